/* rtl/frame_downscale_shade_quantizer_defines.svh */
// Assertion macros used by the frame downscaler top level.
`ifndef FRAME_DOWNSCALE_SHADE_QUANTIZER_DEFINES_SVH
`define FRAME_DOWNSCALE_SHADE_QUANTIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDSQ_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDSQ_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fdsq_pkg.sv */
package fdsq_pkg;

    // Configuration port address width: six registers at byte addresses 0 to 20.
    localparam int unsigned ADDR_W = 5;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        IDX_SCALE_WIDTH  = 3'd0,
        IDX_SCALE_HEIGHT = 3'd1,
        IDX_X_OFFSET     = 3'd2,
        IDX_Y_OFFSET     = 3'd3,
        IDX_GRAY_MODE    = 3'd4,
        IDX_COLOR_MODE   = 3'd5
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [7:0] RST_SCALE_WIDTH  = 8'd71;
    localparam logic [7:0] RST_SCALE_HEIGHT = 8'd64;
    localparam logic [6:0] RST_X_OFFSET     = 7'd29;
    localparam logic [6:0] RST_Y_OFFSET     = 7'd0;
    localparam logic       RST_GRAY_MODE    = 1'b1;
    localparam logic       RST_COLOR_MODE   = 1'b0;

    // Current register contents as seen by the datapath.
    typedef struct packed {
        logic [7:0] scale_width;
        logic [7:0] scale_height;
        logic [6:0] x_offset;
        logic [6:0] y_offset;
        logic       gray_mode;
        logic       color_mode;
    } cfg_t;

    // Shade codes; white is never emitted.
    typedef enum logic [1:0] {
        SHADE_WHITE = 2'd0,
        SHADE_LIGHT = 2'd1,
        SHADE_DARK  = 2'd2,
        SHADE_BLACK = 2'd3
    } shade_t;

    // Classic path thresholds on color bits 4:2.
    localparam logic [2:0] CLS_BLACK_ABOVE = 3'd6;
    localparam logic [2:0] CLS_DARK_ABOVE  = 3'd4;
    localparam logic [2:0] CLS_LIGHT_ABOVE = 3'd2;

    // Luma path thresholds.
    localparam logic [7:0] LUMA_BLACK_MIN = 8'd192;
    localparam logic [7:0] LUMA_DARK_MIN  = 8'd128;
    localparam logic [7:0] LUMA_LIGHT_MIN = 8'd64;

    // Luma of each RRRGGGBB code.
    localparam logic [7:0] LUMA_ROM [256] = '{
        8'd255, 8'd249, 8'd243, 8'd237, 8'd229, 8'd223, 8'd217, 8'd211,
        8'd203, 8'd197, 8'd191, 8'd185, 8'd177, 8'd171, 8'd165, 8'd159,
        8'd151, 8'd145, 8'd139, 8'd133, 8'd125, 8'd119, 8'd113, 8'd107,
        8'd99,  8'd93,  8'd87,  8'd81,  8'd73,  8'd67,  8'd61,
        8'd55,  8'd248, 8'd242, 8'd236, 8'd229, 8'd222, 8'd216, 8'd209,
        8'd203, 8'd196, 8'd190, 8'd183, 8'd177, 8'd170, 8'd163, 8'd157,
        8'd151, 8'd144, 8'd137, 8'd131, 8'd125, 8'd117, 8'd111, 8'd105,
        8'd99,  8'd91,  8'd85,  8'd79,  8'd73,  8'd65,
        8'd59,  8'd53,  8'd47,  8'd240, 8'd234, 8'd228, 8'd222, 8'd214,
        8'd208, 8'd202, 8'd196, 8'd188, 8'd182, 8'd176, 8'd170, 8'd162,
        8'd156, 8'd150, 8'd143, 8'd136, 8'd130, 8'd124, 8'd117, 8'd110,
        8'd104, 8'd97,  8'd91,  8'd84,  8'd78,  8'd71,
        8'd65,  8'd58,  8'd51,  8'd45,  8'd39,  8'd232, 8'd226, 8'd220,
        8'd214, 8'd206, 8'd200, 8'd194, 8'd188, 8'd180, 8'd174, 8'd168,
        8'd162, 8'd154, 8'd148, 8'd142, 8'd136, 8'd128, 8'd122, 8'd116,
        8'd110, 8'd102, 8'd96,  8'd90,  8'd84,  8'd76,
        8'd70,  8'd64,  8'd58,  8'd50,  8'd44,  8'd38,  8'd31,  8'd225,
        8'd218, 8'd212, 8'd206, 8'd198, 8'd192, 8'd186, 8'd180, 8'd172,
        8'd166, 8'd160, 8'd154, 8'd146, 8'd140, 8'd134, 8'd128, 8'd120,
        8'd114, 8'd108, 8'd102, 8'd94,  8'd88,  8'd82,
        8'd76,  8'd68,  8'd62,  8'd56,  8'd50,  8'd42,  8'd36,  8'd30,
        8'd24,  8'd217, 8'd211, 8'd205, 8'd198, 8'd191, 8'd185, 8'd178,
        8'd172, 8'd165, 8'd159, 8'd152, 8'd146, 8'd139, 8'd132, 8'd126,
        8'd120, 8'd113, 8'd106, 8'd100, 8'd94,  8'd86,
        8'd80,  8'd74,  8'd68,  8'd60,  8'd54,  8'd48,  8'd42,  8'd34,
        8'd28,  8'd22,  8'd16,  8'd209, 8'd203, 8'd197, 8'd191, 8'd183,
        8'd177, 8'd171, 8'd165, 8'd157, 8'd151, 8'd145, 8'd139, 8'd131,
        8'd125, 8'd119, 8'd112, 8'd105, 8'd99,  8'd93,
        8'd86,  8'd79,  8'd73,  8'd66,  8'd60,  8'd53,  8'd47,  8'd40,
        8'd34,  8'd27,  8'd20,  8'd14,  8'd8,   8'd201, 8'd195, 8'd189,
        8'd183, 8'd175, 8'd169, 8'd163, 8'd157, 8'd149, 8'd143, 8'd137,
        8'd131, 8'd123, 8'd117, 8'd111, 8'd105, 8'd97,
        8'd91,  8'd85,  8'd79,  8'd71,  8'd65,  8'd59,  8'd53,  8'd45,
        8'd39,  8'd33,  8'd27,  8'd19,  8'd13,  8'd7,   8'd0
    };

endpackage

/* rtl/fdsq_regs.sv */
module fdsq_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdsq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output fdsq_pkg::cfg_t              cfg
);
    import fdsq_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    // Word index of the access and the write strobe of the access phase.
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register update on a write beat.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                IDX_SCALE_WIDTH:  cfg_next.scale_width  = pwdata[7:0];
                IDX_SCALE_HEIGHT: cfg_next.scale_height = pwdata[7:0];
                IDX_X_OFFSET:     cfg_next.x_offset     = pwdata[6:0];
                IDX_Y_OFFSET:     cfg_next.y_offset     = pwdata[6:0];
                IDX_GRAY_MODE:    cfg_next.gray_mode    = pwdata[0];
                IDX_COLOR_MODE:   cfg_next.color_mode   = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_width  <= RST_SCALE_WIDTH;
            cfg_reg.scale_height <= RST_SCALE_HEIGHT;
            cfg_reg.x_offset     <= RST_X_OFFSET;
            cfg_reg.y_offset     <= RST_Y_OFFSET;
            cfg_reg.gray_mode    <= RST_GRAY_MODE;
            cfg_reg.color_mode   <= RST_COLOR_MODE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read data, zero-extended; unused addresses read as zero.
    always_comb
    begin
        case (idx)
            IDX_SCALE_WIDTH:  prdata = {24'd0, cfg_reg.scale_width};
            IDX_SCALE_HEIGHT: prdata = {24'd0, cfg_reg.scale_height};
            IDX_X_OFFSET:     prdata = {25'd0, cfg_reg.x_offset};
            IDX_Y_OFFSET:     prdata = {25'd0, cfg_reg.y_offset};
            IDX_GRAY_MODE:    prdata = {31'd0, cfg_reg.gray_mode};
            IDX_COLOR_MODE:   prdata = {31'd0, cfg_reg.color_mode};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/fdsq_axis.sv */
module fdsq_axis #(
    parameter int unsigned SRC = 160
) (
    input  logic       clk,
    input  logic [7:0] coord,
    input  logic [7:0] tgt_cfg,
    output logic       keep,
    output logic [7:0] pos
);
    import fdsq_pkg::*;

    // Reciprocal for an exact divide of a 16-bit value by SRC.
    localparam int unsigned     SHIFT      = 24;
    localparam longint unsigned RECIP_FULL = ((longint'(1) << SHIFT) + SRC - 1) / SRC;
    localparam logic [24:0]     RECIP      = 25'(RECIP_FULL);
    localparam logic [8:0]      SRC_V      = 9'(SRC);
    localparam logic [15:0]     BIAS       = 16'(SRC - 1);

    logic [7:0]  tgt;
    logic [15:0] n_next;
    logic [15:0] np_next;
    logic [15:0] n1_reg;
    logic [15:0] np1_reg;
    logic [40:0] quot_full;
    logic [15:0] j_next;
    logic [15:0] j2_reg;
    logic [15:0] n2_reg;
    logic [16:0] jsrc_next;
    logic        over_next;
    logic [16:0] jsrc3_reg;
    logic        over3_reg;
    logic [15:0] n3_reg;
    logic [7:0]  pos3_reg;
    logic [16:0] bound;

    // Target size saturates at the source size.
    always_comb
    begin
        if ({1'b0, tgt_cfg} > SRC_V)
            tgt = SRC_V[7:0];
        else
            tgt = tgt_cfg;
    end

    // Stage 1: product of coordinate and target, plus bias for the ceiling.
    assign n_next  = 16'(coord) * 16'(tgt);
    assign np_next = n_next + BIAS;

    // Stage 2: ceiling quotient by reciprocal multiply.
    assign quot_full = 41'(np1_reg) * 41'(RECIP);
    assign j_next    = quot_full[SHIFT+15:SHIFT];

    // Stage 3: scaled index back in source units, and the range check.
    assign jsrc_next = 17'(j2_reg[7:0]) * 17'(SRC_V);
    assign over_next = (|j2_reg[15:8]) || (j2_reg[7:0] >= tgt);

    always_ff @(posedge clk)
    begin
        n1_reg    <= n_next;
        np1_reg   <= np_next;
        j2_reg    <= j_next;
        n2_reg    <= n1_reg;
        jsrc3_reg <= jsrc_next;
        over3_reg <= over_next;
        n3_reg    <= n2_reg;
        pos3_reg  <= j2_reg[7:0];
    end

    // Kept when the index lands strictly before the next source coordinate.
    assign bound = 17'(n3_reg) + 17'(tgt);
    assign keep  = !over3_reg && (jsrc3_reg < bound);
    assign pos   = pos3_reg;

endmodule

/* rtl/fdsq_shade.sv */
module fdsq_shade (
    input  logic             clk,
    input  logic [7:0]       pixel,
    input  logic             gray_mode,
    input  logic             color_mode,
    output fdsq_pkg::shade_t shade
);
    import fdsq_pkg::*;

    logic [2:0] cls_v;
    logic [7:0] luma;
    shade_t     shade_next;
    shade_t     shade1_reg;
    shade_t     shade2_reg;
    shade_t     shade3_reg;

    assign cls_v = pixel[4:2];
    assign luma  = LUMA_ROM[pixel];

    // Quantize to a shade by mode.
    always_comb
    begin
        shade_next = SHADE_WHITE;
        if (color_mode)
        begin
            if (!gray_mode)
                shade_next = (luma >= LUMA_DARK_MIN) ? SHADE_BLACK : SHADE_WHITE;
            else if (luma >= LUMA_BLACK_MIN)
                shade_next = SHADE_BLACK;
            else if (luma >= LUMA_DARK_MIN)
                shade_next = SHADE_DARK;
            else if (luma >= LUMA_LIGHT_MIN)
                shade_next = SHADE_LIGHT;
        end
        else
        begin
            if (!gray_mode)
                shade_next = (cls_v > CLS_DARK_ABOVE) ? SHADE_BLACK : SHADE_WHITE;
            else if (cls_v > CLS_BLACK_ABOVE)
                shade_next = SHADE_BLACK;
            else if (cls_v > CLS_DARK_ABOVE)
                shade_next = SHADE_DARK;
            else if (cls_v > CLS_LIGHT_ABOVE)
                shade_next = SHADE_LIGHT;
        end
    end

    // Delay to line up with the coordinate pipeline.
    always_ff @(posedge clk)
    begin
        shade1_reg <= shade_next;
        shade2_reg <= shade1_reg;
        shade3_reg <= shade2_reg;
    end

    assign shade = shade3_reg;

endmodule

/* rtl/frame_downscale_shade_quantizer.sv */
// Channel   Handshake              Payload
// -------   ---------------------  ----------------------------------------
// pixel in  start, busy            src_x, src_y, pixel_value
// result    done (strobe)          dst_x, dst_y, shade
// config    psel, penable, pwrite  paddr, pwdata, prdata, pready
//
// One pixel beat is taken every clock; busy is always low.
// A result strobe follows its input beat through the input register, the
// column and row index pipelines (multiply, reciprocal divide, back-multiply)
// and the output register; a pixel that is dropped or shaded white gives no
// strobe.
// rst_n clears the pipeline valid flags and loads the register reset values.
// The receiver cannot stall; each result is on the ports for one cycle.
`include "frame_downscale_shade_quantizer_defines.svh"

module frame_downscale_shade_quantizer #(
    parameter int unsigned SRC_WIDTH  = 160,
    parameter int unsigned SRC_HEIGHT = 144
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [7:0]                  src_x,
    input  logic [7:0]                  src_y,
    input  logic [7:0]                  pixel_value,
    output logic                        done,
    output logic [8:0]                  dst_x,
    output logic [8:0]                  dst_y,
    output logic [1:0]                  shade,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdsq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fdsq_pkg::*;

    cfg_t       cfg;
    logic       in_valid_reg;
    logic [7:0] in_x_reg;
    logic [7:0] in_y_reg;
    logic [7:0] in_pix_reg;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       keep_x;
    logic       keep_y;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    shade_t     shade_d;
    logic       emit;
    logic       done_reg;
    logic [8:0] dst_x_reg;
    logic [8:0] dst_y_reg;
    shade_t     shade_reg;
    logic [8:0] lim_x;
    logic [8:0] lim_y;

    assign busy = 1'b0;

    // Configuration registers.
    fdsq_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register.
    always_ff @(posedge clk)
    begin
        in_x_reg   <= src_x;
        in_y_reg   <= src_y;
        in_pix_reg <= pixel_value;
    end

    // Valid flags along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            v1_reg       <= in_valid_reg;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            done_reg     <= emit;
        end
    end

    // Column and row selection.
    fdsq_axis #(.SRC(SRC_WIDTH)) u_axis_x (
        .clk     (clk),
        .coord   (in_x_reg),
        .tgt_cfg (cfg.scale_width),
        .keep    (keep_x),
        .pos     (pos_x)
    );

    fdsq_axis #(.SRC(SRC_HEIGHT)) u_axis_y (
        .clk     (clk),
        .coord   (in_y_reg),
        .tgt_cfg (cfg.scale_height),
        .keep    (keep_y),
        .pos     (pos_y)
    );

    // Shade quantizer, aligned with the selection pipelines.
    fdsq_shade u_shade (
        .clk        (clk),
        .pixel      (in_pix_reg),
        .gray_mode  (cfg.gray_mode),
        .color_mode (cfg.color_mode),
        .shade      (shade_d)
    );

    // Output register.
    assign emit = v3_reg && keep_x && keep_y && (shade_d != SHADE_WHITE);

    always_ff @(posedge clk)
    begin
        dst_x_reg <= 9'(pos_x) + 9'(cfg.x_offset);
        dst_y_reg <= 9'(pos_y) + 9'(cfg.y_offset);
        shade_reg <= shade_d;
    end

    assign done  = done_reg;
    assign dst_x = dst_x_reg;
    assign dst_y = dst_y_reg;
    assign shade = shade_reg;

    // Upper bounds of the output position for the checks below.
    assign lim_x = 9'(cfg.scale_width) + 9'(cfg.x_offset);
    assign lim_y = 9'(cfg.scale_height) + 9'(cfg.y_offset);

    `FDSQ_ASSERT_NOW(a_no_white, clk, rst_n, done, shade_reg != SHADE_WHITE, "white pixel emitted")
    `FDSQ_ASSERT_NOW(a_from_beat, clk, rst_n, done, $past(start, 5), "result without input beat")
    `FDSQ_ASSERT_NOW(a_x_range, clk, rst_n, done, dst_x < lim_x, "dst_x beyond scaled width")
    `FDSQ_ASSERT_NOW(a_y_range, clk, rst_n, done, dst_y < lim_y, "dst_y beyond scaled height")
    `FDSQ_ASSERT_NOW(a_mono_black, clk, rst_n, done && !cfg.gray_mode, shade_reg == SHADE_BLACK, "mono shade not black")

endmodule
